/* rtl/dfxr_pkg.sv */
// ----------------------------------------------------------------------------
// dfxr_pkg
// Shared types and constants of the delimited frame XOR receiver.
// ----------------------------------------------------------------------------
package dfxr_pkg;

  // Widths of the result fields.
  localparam int unsigned ByteW   = 8;
  localparam int unsigned LengthW = 16;
  localparam int unsigned KindW   = 3;

  // Result tdata is payload_byte, command, parameter_res, payload_length,
  // ack_high and ack_low, packed from the lowest bit up.
  localparam int unsigned ResDataW = 5 * ByteW + LengthW;

  // Frame delimiters and the command nibble that marks an ack frame.
  localparam logic [ByteW-1:0] StartByte  = 8'h5B;
  localparam logic [ByteW-1:0] EndByte    = 8'h5D;
  localparam logic [3:0]       AckNibble  = 4'hA;

  // Result kinds, carried on tuser.
  typedef enum logic [KindW-1:0] {
    KindPayload  = 3'd0,
    KindReqOk    = 3'd1,
    KindAckOk    = 3'd2,
    KindChecksum = 3'd3,
    KindFraming  = 3'd4
  } kind_e;

  // One result item as held in the output register and the skid stage.
  typedef struct packed {
    kind_e                kind;
    logic [ResDataW-1:0]  data;
  } result_t;

endpackage

/* rtl/delimited_frame_xor_receiver.sv */
// ----------------------------------------------------------------------------
// delimited_frame_xor_receiver
// Parser for start/end delimited serial frames with an XOR checksum.
// ----------------------------------------------------------------------------
// The block takes one received serial byte per request on its slave stream
// and parses frames that open with 0x5B and close with 0x5D. The byte after
// the start byte is the command; a command whose high nibble is 0xA opens an
// ack frame (code high, code low, XOR, end byte), any other command opens a
// request frame (parameter, 16-bit big-endian length, payload, XOR, end
// byte). The XOR covers every byte from the command up to the last header or
// payload byte. Each payload byte is sent out as a result as soon as it
// arrives, and every frame closes with exactly one verdict: request ok, ack
// ok, checksum error, or framing error. A framing error is also reported
// right after the length bytes when the declared length exceeds MAX_PAYLOAD.
// Bytes outside a frame other than the start byte are dropped silently.
// Throughput is one byte per clock cycle while the skid stage is empty: the
// frame state is updated in the cycle a byte is accepted, and the result
// goes into an output register backed by a one-entry skid stage, so a byte
// is accepted even while a result waits to be taken. The result reaches the
// master stream from the output register. s_axis_tready drops only while
// the skid stage holds a result.
module delimited_frame_xor_receiver #(
  parameter int unsigned MAX_PAYLOAD = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Slave stream: received bytes.
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,   // [7:0] rx_byte
  // Master stream: results.
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [7:0] payload_byte, [15:8] command, [23:16] parameter_res,
  // [39:24] payload_length, [47:40] ack_high, [55:48] ack_low
  output logic [dfxr_pkg::ResDataW-1:0] m_axis_tdata,
  output dfxr_pkg::kind_e              m_axis_tuser    // [2:0] kind
);

  import dfxr_pkg::*;

  // The byte counter only has to reach the largest accepted length.
  localparam int unsigned CntW = $clog2(MAX_PAYLOAD + 1);
  localparam logic [LengthW-1:0] MaxLen = LengthW'(MAX_PAYLOAD);

  typedef enum logic [3:0] {
    PhHunt,
    PhCmd,
    PhAckHi,
    PhAckLo,
    PhAckXor,
    PhAckEnd,
    PhReqParam,
    PhLenHi,
    PhLenLo,
    PhPayload,
    PhReqXor,
    PhReqEnd
  } phase_e;

  phase_e             phase_q, phase_d;
  logic [ByteW-1:0]   cmd_q, cmd_d;
  logic [ByteW-1:0]   param_q, param_d;
  logic [LengthW-1:0] length_q, length_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [ByteW-1:0]   xor_q, xor_d;
  logic [ByteW-1:0]   code_hi_q, code_hi_d;
  logic [ByteW-1:0]   code_lo_q, code_lo_d;
  logic               check_ok_q, check_ok_d;

  logic               accept;
  logic [ByteW-1:0]   rx_byte;
  logic               emit_valid;
  kind_e              emit_kind;
  logic [ByteW-1:0]   emit_pb;
  logic [LengthW-1:0] length_low;
  logic [CntW-1:0]    count_inc;
  result_t            emit_res;

  // Output register and skid stage.
  logic               out_valid_q;
  result_t            out_q;
  logic               skid_valid_q;
  result_t            skid_q;

  assign rx_byte       = s_axis_tdata;
  assign s_axis_tready = !skid_valid_q;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Length as it stands once the low length byte has been merged in.
  assign length_low = {length_q[LengthW-1:ByteW], rx_byte};
  assign count_inc  = count_q + CntW'(1);

  // Next frame state and the result, if any, for the byte on the input.
  always_comb begin
    phase_d    = phase_q;
    cmd_d      = cmd_q;
    param_d    = param_q;
    length_d   = length_q;
    count_d    = count_q;
    xor_d      = xor_q;
    code_hi_d  = code_hi_q;
    code_lo_d  = code_lo_q;
    check_ok_d = check_ok_q;
    emit_valid = 1'b0;
    emit_kind  = KindPayload;
    emit_pb    = '0;

    case (phase_q)
      PhHunt: begin
        if (rx_byte == StartByte) begin
          phase_d = PhCmd;
        end
      end
      PhCmd: begin
        cmd_d      = rx_byte;
        xor_d      = rx_byte;
        param_d    = '0;
        length_d   = '0;
        count_d    = '0;
        code_hi_d  = '0;
        code_lo_d  = '0;
        check_ok_d = 1'b0;
        phase_d    = (rx_byte[7:4] == AckNibble) ? PhAckHi : PhReqParam;
      end
      PhAckHi: begin
        code_hi_d = rx_byte;
        xor_d     = xor_q ^ rx_byte;
        phase_d   = PhAckLo;
      end
      PhAckLo: begin
        code_lo_d = rx_byte;
        xor_d     = xor_q ^ rx_byte;
        phase_d   = PhAckXor;
      end
      PhAckXor: begin
        check_ok_d = (rx_byte == xor_q);
        phase_d    = PhAckEnd;
      end
      PhAckEnd: begin
        phase_d    = PhHunt;
        emit_valid = 1'b1;
        if (rx_byte != EndByte) begin
          emit_kind = KindFraming;
        end else begin
          emit_kind = check_ok_q ? KindAckOk : KindChecksum;
        end
      end
      PhReqParam: begin
        param_d = rx_byte;
        xor_d   = xor_q ^ rx_byte;
        phase_d = PhLenHi;
      end
      PhLenHi: begin
        length_d = {rx_byte, {ByteW{1'b0}}};
        xor_d    = xor_q ^ rx_byte;
        phase_d  = PhLenLo;
      end
      PhLenLo: begin
        length_d = length_low;
        xor_d    = xor_q ^ rx_byte;
        count_d  = '0;
        if (length_low > MaxLen) begin
          phase_d    = PhHunt;
          emit_valid = 1'b1;
          emit_kind  = KindFraming;
        end else if (length_low == '0) begin
          phase_d = PhReqXor;
        end else begin
          phase_d = PhPayload;
        end
      end
      PhPayload: begin
        xor_d      = xor_q ^ rx_byte;
        count_d    = count_inc;
        emit_valid = 1'b1;
        emit_kind  = KindPayload;
        emit_pb    = rx_byte;
        if (LengthW'(count_inc) >= length_q) begin
          phase_d = PhReqXor;
        end
      end
      PhReqXor: begin
        check_ok_d = (rx_byte == xor_q);
        phase_d    = PhReqEnd;
      end
      PhReqEnd: begin
        phase_d    = PhHunt;
        emit_valid = 1'b1;
        if (rx_byte != EndByte) begin
          emit_kind = KindFraming;
        end else begin
          emit_kind = check_ok_q ? KindReqOk : KindChecksum;
        end
      end
      default: begin
        phase_d = PhHunt;
      end
    endcase
  end

  // Ack frames never load the request fields and request frames never load
  // the ack codes, and the command byte clears all of them, so the frame
  // registers can be reported as they stand. Only the length check right
  // after the low length byte needs the freshly merged length.
  always_comb begin
    emit_res.kind = emit_kind;
    emit_res.data = {code_lo_q, code_hi_q,
                     (phase_q == PhLenLo) ? length_low : length_q,
                     param_q, cmd_q, emit_pb};
  end

  // Frame state, updated in the cycle a byte is accepted.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhHunt;
      cmd_q      <= '0;
      param_q    <= '0;
      length_q   <= '0;
      count_q    <= '0;
      xor_q      <= '0;
      code_hi_q  <= '0;
      code_lo_q  <= '0;
      check_ok_q <= 1'b0;
    end else if (accept) begin
      phase_q    <= phase_d;
      cmd_q      <= cmd_d;
      param_q    <= param_d;
      length_q   <= length_d;
      count_q    <= count_d;
      xor_q      <= xor_d;
      code_hi_q  <= code_hi_d;
      code_lo_q  <= code_lo_d;
      check_ok_q <= check_ok_d;
    end
  end

  // Valid flags of the output register and skid stage. The skid stage only
  // fills when the output register is held by a stalled result; while it is
  // full the input is closed, so nothing new arrives when it drains.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q  <= skid_valid_q || (accept && emit_valid);
      skid_valid_q <= 1'b0;
    end else if (accept && emit_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || m_axis_tready) begin
      out_q <= skid_valid_q ? skid_q : emit_res;
    end else if (accept && emit_valid) begin
      skid_q <= emit_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q.data;
  assign m_axis_tuser  = out_q.kind;

endmodule

/* rtl/dfxr_checker.sv */
// ----------------------------------------------------------------------------
// dfxr_port_checks
// Port-level checks of the delimited frame XOR receiver.
// ----------------------------------------------------------------------------
module dfxr_port_checks (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [dfxr_pkg::ResDataW-1:0] m_axis_tdata,
  input dfxr_pkg::kind_e               m_axis_tuser
);

  import dfxr_pkg::*;

  // A stalled result holds its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // Only payload results carry a payload byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != KindPayload) |-> m_axis_tdata[7:0] == 8'h00)
    else $error("payload byte set on a verdict");

  // Request results never carry ack codes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KindPayload || m_axis_tuser == KindReqOk)
      |-> m_axis_tdata[55:40] == 16'h0000)
    else $error("ack codes set on a request result");

  // Ack ok verdicts never carry a parameter or a length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KindAckOk) |-> m_axis_tdata[39:16] == 24'h000000)
    else $error("request fields set on an ack verdict");

  // A payload byte only comes from a frame with a nonzero length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KindPayload) |-> m_axis_tdata[39:24] != 16'h0000)
    else $error("payload byte in a zero length frame");

endmodule

bind delimited_frame_xor_receiver dfxr_port_checks u_dfxr_port_checks (.*);

/* tb/dfxr_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dfxr_checker
// Watches both streams of the frame receiver, predicts and compares results.
// ----------------------------------------------------------------------------
module dfxr_checker
  import dfxr_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [ResDataW-1:0] m_axis_tdata,
  input  kind_e               m_axis_tuser,
  output int                  fail_count_o,
  output int                  pending_o
);

  // Mismatches beyond this many are still counted, just not printed.
  localparam int MaxReports = 30;

  typedef enum logic [3:0] {
    PhHunt,
    PhCommand,
    PhAckHigh,
    PhAckLow,
    PhAckCheck,
    PhAckEnd,
    PhParam,
    PhLenHigh,
    PhLenLow,
    PhPayload,
    PhReqCheck,
    PhReqEnd
  } parse_phase_e;

  typedef struct {
    kind_e       kind;
    logic [7:0]  payload_byte;
    logic [7:0]  command;
    logic [7:0]  parameter_res;
    logic [15:0] payload_length;
    logic [7:0]  ack_high;
    logic [7:0]  ack_low;
  } frame_result_t;

  parse_phase_e  phase_q;
  logic [7:0]    cmd_q;
  logic [7:0]    param_q;
  logic [15:0]   length_q;
  logic [15:0]   count_q;
  logic [7:0]    xor_q;
  logic [7:0]    code_high_q;
  logic [7:0]    code_low_q;
  logic          check_ok_q;
  frame_result_t expected_results[$];

  initial fail_count_o = 0;
  initial pending_o = 0;

  task automatic report_mismatch(input string msg);
    if (fail_count_o < MaxReports) $display("[%0t] checker: %s", $time, msg);
    fail_count_o++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got, want);
    if (got !== want) report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
  endtask

  // Builds a result from the frame registers; ack frames zero the request
  // fields and request frames zero the ack codes.
  function automatic frame_result_t frame_report(input kind_e k, input logic [7:0] pb,
                                                 input bit ack_frame);
    frame_result_t r;
    r.kind           = k;
    r.payload_byte   = pb;
    r.command        = cmd_q;
    r.parameter_res  = ack_frame ? 8'h00 : param_q;
    r.payload_length = ack_frame ? 16'h0000 : length_q;
    r.ack_high       = ack_frame ? code_high_q : 8'h00;
    r.ack_low        = ack_frame ? code_low_q : 8'h00;
    return r;
  endfunction

  task automatic advance_parser(input logic [7:0] rx);
    case (phase_q)
      PhHunt: begin
        if (rx == StartByte) phase_q = PhCommand;
      end
      PhCommand: begin
        cmd_q       = rx;
        xor_q       = rx;
        param_q     = 8'h00;
        length_q    = 16'h0000;
        count_q     = 16'h0000;
        code_high_q = 8'h00;
        code_low_q  = 8'h00;
        check_ok_q  = 1'b0;
        phase_q     = (rx[7:4] == AckNibble) ? PhAckHigh : PhParam;
      end
      PhAckHigh: begin
        code_high_q = rx;
        xor_q      ^= rx;
        phase_q     = PhAckLow;
      end
      PhAckLow: begin
        code_low_q = rx;
        xor_q     ^= rx;
        phase_q    = PhAckCheck;
      end
      PhAckCheck: begin
        check_ok_q = (rx == xor_q);
        phase_q    = PhAckEnd;
      end
      PhAckEnd: begin
        phase_q = PhHunt;
        // A wrong end byte wins over a wrong checksum.
        if (rx != EndByte) begin
          expected_results.push_back(frame_report(KindFraming, 8'h00, 1'b1));
        end else begin
          expected_results.push_back(
            frame_report(check_ok_q ? KindAckOk : KindChecksum, 8'h00, 1'b1));
        end
      end
      PhParam: begin
        param_q = rx;
        xor_q  ^= rx;
        phase_q = PhLenHigh;
      end
      PhLenHigh: begin
        length_q = {rx, 8'h00};
        xor_q   ^= rx;
        phase_q  = PhLenLow;
      end
      PhLenLow: begin
        length_q[7:0] = rx;
        xor_q        ^= rx;
        count_q       = 16'h0000;
        if (length_q > MAX_PAYLOAD) begin
          phase_q = PhHunt;
          expected_results.push_back(frame_report(KindFraming, 8'h00, 1'b0));
        end else begin
          phase_q = (length_q == 16'h0000) ? PhReqCheck : PhPayload;
        end
      end
      PhPayload: begin
        xor_q  ^= rx;
        count_q = count_q + 16'd1;
        if (count_q >= length_q) phase_q = PhReqCheck;
        expected_results.push_back(frame_report(KindPayload, rx, 1'b0));
      end
      PhReqCheck: begin
        check_ok_q = (rx == xor_q);
        phase_q    = PhReqEnd;
      end
      PhReqEnd: begin
        phase_q = PhHunt;
        if (rx != EndByte) begin
          expected_results.push_back(frame_report(KindFraming, 8'h00, 1'b0));
        end else begin
          expected_results.push_back(
            frame_report(check_ok_q ? KindReqOk : KindChecksum, 8'h00, 1'b0));
        end
      end
      default: begin
        phase_q = PhHunt;
      end
    endcase
  endtask

  task automatic compare_result();
    frame_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("result with nothing expected, kind %0d data %h",
                                m_axis_tuser, m_axis_tdata));
    end else begin
      want = expected_results.pop_front();
      check_field("kind", 16'(m_axis_tuser), 16'(want.kind));
      check_field("payload_byte", 16'(m_axis_tdata[7:0]), 16'(want.payload_byte));
      check_field("command", 16'(m_axis_tdata[15:8]), 16'(want.command));
      check_field("parameter_res", 16'(m_axis_tdata[23:16]), 16'(want.parameter_res));
      check_field("payload_length", m_axis_tdata[39:24], want.payload_length);
      check_field("ack_high", 16'(m_axis_tdata[47:40]), 16'(want.ack_high));
      check_field("ack_low", 16'(m_axis_tdata[55:48]), 16'(want.ack_low));
    end
  endtask

  // Results are registered after the byte that causes them, so taking the
  // result side first at an edge never races the prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     = PhHunt;
      cmd_q       = 8'h00;
      param_q     = 8'h00;
      length_q    = 16'h0000;
      count_q     = 16'h0000;
      xor_q       = 8'h00;
      code_high_q = 8'h00;
      code_low_q  = 8'h00;
      check_ok_q  = 1'b0;
      expected_results.delete();
      pending_o   = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) compare_result();
      if (s_axis_tvalid && s_axis_tready) advance_parser(s_axis_tdata);
      pending_o = expected_results.size();
    end
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the delimited frame XOR receiver.
// ----------------------------------------------------------------------------
// Feeds a byte stream of well-formed ack and request frames with random
// content, mixed with corrupted checksums, wrong end bytes, over-long length
// fields, truncated frames and loose noise. Both stream sides pause at
// random between requests, with stretches of full-rate flow. The checker
// beside the block predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module tb_top;
  import dfxr_pkg::*;

  localparam int unsigned MaxPayload  = 256;
  localparam int unsigned NumItems    = 1750;
  localparam int unsigned MaxIdle     = 17;
  // Only a couple of frames at or near the maximum length, they are long.
  localparam int unsigned FullFrames  = 2;
  localparam int unsigned DrainCycles = 16;
  // Covers the slowest correct run, of roughly 2000 bytes.
  localparam int unsigned CycleLimit  = 500000;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = 8'h00;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [ResDataW-1:0] m_axis_tdata;
  kind_e               m_axis_tuser;

  int          fail_count;
  int          pending_count;
  int unsigned cycle_count = 0;

  // Byte stream to send, and the running XOR of the frame being built.
  logic [7:0] rx_stream[$];
  logic [7:0] running_xor;
  // Set during stretches in which neither side pauses.
  bit         steady_flow = 1'b0;

  delimited_frame_xor_receiver #(
    .MAX_PAYLOAD(MaxPayload)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  dfxr_checker #(
    .MAX_PAYLOAD(MaxPayload)
  ) checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .fail_count_o (fail_count),
    .pending_o    (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Appends a byte that the frame checksum covers.
  task automatic put_covered(input logic [7:0] b);
    rx_stream.push_back(b);
    running_xor ^= b;
  endtask

  // Appends the checksum and end byte, either of them optionally wrong.
  task automatic add_close(input bit bad_xor, input bit bad_end);
    logic [7:0] chk;
    logic [7:0] tail;
    chk  = bad_xor ? running_xor ^ 8'($urandom_range(1, 255)) : running_xor;
    tail = EndByte;
    if (bad_end) begin
      tail = 8'($urandom_range(0, 255));
      if (tail == EndByte) tail = 8'h00;
    end
    rx_stream.push_back(chk);
    rx_stream.push_back(tail);
  endtask

  task automatic add_ack(input logic [7:0] cmd, hi, lo, input bit bad_xor, bad_end);
    rx_stream.push_back(StartByte);
    running_xor = 8'h00;
    put_covered(cmd);
    put_covered(hi);
    put_covered(lo);
    add_close(bad_xor, bad_end);
  endtask

  // Payload bytes are random. A length over the maximum ends the frame right
  // after the length field, since the block drops back to hunting there.
  task automatic add_request(input logic [7:0] cmd, prm, input logic [15:0] len,
                             input bit bad_xor, bad_end);
    rx_stream.push_back(StartByte);
    running_xor = 8'h00;
    put_covered(cmd);
    put_covered(prm);
    put_covered(len[15:8]);
    put_covered(len[7:0]);
    if (len <= MaxPayload) begin
      for (int i = 0; i < len; i++) put_covered(8'($urandom_range(0, 255)));
      add_close(bad_xor, bad_end);
    end
  endtask

  function automatic logic [7:0] request_command();
    logic [7:0] cmd;
    do cmd = 8'($urandom_range(0, 255)); while (cmd[7:4] == AckNibble);
    return cmd;
  endfunction

  // Request side: builds the byte stream, sends it, then waits for the last
  // result and gives the verdict.
  initial begin
    int unsigned pick;
    int unsigned sel;
    int unsigned full_done;
    int unsigned gap;
    logic [15:0] len;

    full_done = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed frames: a good ack, an ack with a bad checksum and extreme
    // codes, an empty request, the start byte used as a command together with
    // an all-ones length, and a one-byte request with a wrong end byte.
    add_ack({AckNibble, 4'h5}, 8'h12, 8'h34, 1'b0, 1'b0);
    add_ack({AckNibble, 4'hF}, 8'h00, 8'hFF, 1'b1, 1'b0);
    add_request(8'h00, 8'hFF, 16'd0, 1'b0, 1'b0);
    add_request(StartByte, 8'h00, 16'hFFFF, 1'b0, 1'b0);
    add_request(8'hFF, 8'h80, 16'd1, 1'b0, 1'b1);

    // Random part: mostly well-formed frames with random content, some
    // corrupted ones, truncated frames and noise between frames.
    while (rx_stream.size() < NumItems) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        repeat ($urandom_range(1, 4)) rx_stream.push_back(8'($urandom_range(0, 255)));
      end else if (pick < 10) begin
        rx_stream.push_back(StartByte);
        repeat ($urandom_range(1, 6)) rx_stream.push_back(8'($urandom_range(0, 255)));
      end else if (pick < 35) begin
        add_ack({AckNibble, 4'($urandom_range(0, 15))}, 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0,
                $urandom_range(0, 9) == 0);
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 60) begin
          len = 16'($urandom_range(0, 8));
        end else if (sel < 80) begin
          len = 16'($urandom_range(9, 40));
        end else if (sel < 95) begin
          case ($urandom_range(0, 3))
            0:       len = 16'(MaxPayload + 1);
            1:       len = 16'hFFFF;
            default: len = 16'($urandom_range(MaxPayload + 1, 65535));
          endcase
        end else if (full_done < FullFrames) begin
          len = 16'(MaxPayload - full_done);
          full_done++;
        end else begin
          len = 16'($urandom_range(0, 8));
        end
        add_request(request_command(), 8'($urandom_range(0, 255)), len,
                    $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0);
      end
    end

    @(posedge clk_i);
    foreach (rx_stream[i]) begin
      steady_flow = ((i / 200) % 4) == 3;
      gap = steady_flow ? 0 : $urandom_range(0, MaxIdle);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= rx_stream[i];
      do @(posedge clk_i); while (!s_axis_tready);
    end
    s_axis_tvalid <= 1'b0;
    steady_flow = 1'b0;

    // Let the checker take in the last request, then drain.
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Result side: random stalls before each result is taken.
  initial begin
    int unsigned stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, MaxIdle);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Watchdog against a hung handshake or results that never arrive.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule

/* delimited_frame_xor_receiver.f */
rtl/dfxr_pkg.sv
rtl/delimited_frame_xor_receiver.sv
rtl/dfxr_checker.sv
tb/dfxr_checker.sv
tb/tb_top.sv
